// ===== rtl/oct_pkg.sv =====
// oct_pkg: shared types, constants and the arctangent table for octant_lut_arctan2.
// Depends on nothing; every rtl module uses it by scoped names.
`timescale 1ns / 1ps
package oct_pkg;

  localparam int CoordW    = 16;
  localparam int MagW      = CoordW + 1;  // true magnitude, 32768 fits
  localparam int RemW      = MagW + 1;    // partial remainder, doubled each step
  localparam int QuoW      = 5;           // quotient 0..16
  localparam int NumCells  = QuoW;        // one quotient bit per cell
  localparam int AngleW    = 8;

  localparam logic signed [AngleW-1:0] QuarterTurn = 8'sd32;
  localparam logic signed [AngleW-1:0] HalfTurn    = 8'sd64;
  localparam logic [QuoW-1:0]          MaxIdx      = 5'd16;

  // Item state handed from cell to cell.
  typedef struct packed {
    logic              zero;     // origin: both magnitudes zero
    logic              mirror;   // |y| >= |x|, reflect about the diagonal
    logic              x_neg;
    logic              y_neg;
    logic [MagW-1:0]   divisor;  // larger magnitude
    logic [RemW-1:0]   rem;      // running partial remainder
    logic [QuoW-1:0]   quo;      // quotient bits so far, newest in bit 0
  } cell_t;

  // Arctangent over 0..45 degrees, 16 steps, scaled to 0..15.
  function automatic logic [3:0] arctan_rom(input logic [QuoW-1:0] idx);
    logic [3:0] v;
    case (idx)
      5'd0:    v = 4'd0;
      5'd1:    v = 4'd1;
      5'd2:    v = 4'd2;
      5'd3:    v = 4'd3;
      5'd4:    v = 4'd4;
      5'd5:    v = 4'd5;
      5'd6:    v = 4'd7;
      5'd7:    v = 4'd8;
      5'd8:    v = 4'd9;
      5'd9:    v = 4'd10;
      5'd10:   v = 4'd11;
      5'd11:   v = 4'd12;
      5'd12:   v = 4'd13;
      5'd13:   v = 4'd13;
      5'd14:   v = 4'd14;
      5'd15:   v = 4'd15;
      default: v = 4'd15;  // 16, and codes above the quotient range
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/oct_fold.sv =====
// oct_fold: first stage, takes magnitudes and signs and sorts them into divisor and dividend.
// Depends on oct_pkg.
`timescale 1ns / 1ps
module oct_fold (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [oct_pkg::CoordW-1:0]  y_coord,
  input  logic signed [oct_pkg::CoordW-1:0]  x_coord,
  output logic                               valid_r,
  output oct_pkg::cell_t                     data_r
);

  logic [oct_pkg::MagW-1:0] ay;
  logic [oct_pkg::MagW-1:0] ax;
  oct_pkg::cell_t           data_nxt;

  always_comb begin
    ay = y_coord[oct_pkg::CoordW-1] ? (oct_pkg::MagW'(0) - {y_coord[oct_pkg::CoordW-1], y_coord})
                                    : {1'b0, y_coord};
    ax = x_coord[oct_pkg::CoordW-1] ? (oct_pkg::MagW'(0) - {x_coord[oct_pkg::CoordW-1], x_coord})
                                    : {1'b0, x_coord};
    data_nxt.x_neg   = x_coord[oct_pkg::CoordW-1];
    data_nxt.y_neg   = y_coord[oct_pkg::CoordW-1];
    data_nxt.mirror  = !(ax > ay);
    data_nxt.zero    = (ax == '0) && (ay == '0);
    data_nxt.divisor = data_nxt.mirror ? ay : ax;
    data_nxt.rem     = {1'b0, (data_nxt.mirror ? ax : ay)};
    data_nxt.quo     = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== rtl/oct_div_cell.sv =====
// oct_div_cell: one restoring-division cell, resolves one quotient bit per item and passes it on.
// Depends on oct_pkg.
`timescale 1ns / 1ps
module oct_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           valid_in,
  input  oct_pkg::cell_t data_in,
  output logic           valid_r,
  output oct_pkg::cell_t data_r
);

  logic                     fits;
  logic [oct_pkg::RemW-1:0] diff;
  oct_pkg::cell_t           data_nxt;

  always_comb begin
    fits     = data_in.rem >= {1'b0, data_in.divisor};
    diff     = fits ? (data_in.rem - {1'b0, data_in.divisor}) : data_in.rem;
    data_nxt = data_in;
    // double the remainder for the next, less significant bit
    data_nxt.rem = {diff[oct_pkg::RemW-2:0], 1'b0};
    data_nxt.quo = {data_in.quo[oct_pkg::QuoW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== rtl/oct_unfold.sv =====
// oct_unfold: last stage, table lookup, mirror about the diagonal, unfold into the quadrant.
// Depends on oct_pkg; holds the output register.
`timescale 1ns / 1ps
module oct_unfold (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               valid_in,
  input  oct_pkg::cell_t                     data_in,
  output logic                               valid_r,
  output logic signed [oct_pkg::AngleW-1:0]  angle_r
);

  logic signed [oct_pkg::AngleW-1:0] tab;
  logic signed [oct_pkg::AngleW-1:0] oct_a;
  logic signed [oct_pkg::AngleW-1:0] angle_nxt;

  always_comb begin
    // origin has no valid quotient: treat the table value as zero
    tab   = data_in.zero ? '0
                         : oct_pkg::AngleW'({1'b0, oct_pkg::arctan_rom(data_in.quo)});
    oct_a = data_in.mirror ? (oct_pkg::QuarterTurn - tab) : tab;
    if (!data_in.x_neg && !data_in.y_neg) begin
      angle_nxt = oct_a;
    end else if (data_in.x_neg && !data_in.y_neg) begin
      angle_nxt = oct_pkg::HalfTurn - oct_a;
    end else if (!data_in.x_neg && data_in.y_neg) begin
      angle_nxt = -oct_a;
    end else begin
      angle_nxt = oct_a - oct_pkg::HalfTurn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
    end
  end

endmodule

// ===== rtl/octant_lut_arctan2.sv =====
// octant_lut_arctan2: four-quadrant arctangent on a 128-steps-per-turn scale, as a row of cells.
// Depends on oct_pkg, oct_fold, oct_div_cell and oct_unfold.
//
//   channel | direction | width | contents
//   --------+-----------+-------+------------------------------------------
//   in_     | slave     | 32    | tdata: y_coord [15:0], x_coord [31:16]
//   out_    | master    | 8     | tdata: angle [7:0], signed 1/128 turn
//
// Throughput: one transaction per cycle sustained while out_tready stays high; the
//   row is one fold stage, five division cells (one quotient bit each)
//   and one unfold stage that holds the output register.
// Reset: rst_n synchronous, active low; clears the valid bits of every stage.
// Stalls: the whole row advances together whenever the output register is empty
//   or being taken; when out_tready holds low with a result waiting, every stage
//   holds and in_tready drops in the same cycle.
`timescale 1ns / 1ps
module octant_lut_arctan2 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] y_coord, [31:16] x_coord
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [7:0] angle
);

  // Row advance: output register free, or its transaction completes now.
  logic advance;

  logic                 fold_valid;
  oct_pkg::cell_t       fold_data;
  logic                 cell_valid [oct_pkg::NumCells];
  oct_pkg::cell_t       cell_data  [oct_pkg::NumCells];
  logic signed [oct_pkg::AngleW-1:0] angle;

  assign advance   = !out_tvalid || out_tready;
  assign in_tready = advance;

  // Fold: magnitudes, signs, pick divisor and dividend.
  oct_fold u_fold (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .in_valid (in_tvalid),
    .y_coord  (in_tdata[15:0]),
    .x_coord  (in_tdata[31:16]),
    .valid_r  (fold_valid),
    .data_r   (fold_data)
  );

  // Division row: each cell resolves one bit of 16*small/large, MSB first.
  for (genvar i = 0; i < oct_pkg::NumCells; i++) begin : g_cell
    if (i == 0) begin : g_head
      oct_div_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .valid_in (fold_valid),
        .data_in  (fold_data),
        .valid_r  (cell_valid[i]),
        .data_r   (cell_data[i])
      );
    end else begin : g_body
      oct_div_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .valid_in (cell_valid[i-1]),
        .data_in  (cell_data[i-1]),
        .valid_r  (cell_valid[i]),
        .data_r   (cell_data[i])
      );
    end
  end

  // Unfold: table, mirror, quadrant; drives the output register.
  oct_unfold u_unfold (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .valid_in (cell_valid[oct_pkg::NumCells-1]),
    .data_in  (cell_data[oct_pkg::NumCells-1]),
    .valid_r  (out_tvalid),
    .angle_r  (angle)
  );

  assign out_tdata = angle;

  // Away from the origin, the quotient leaving the last cell stays within the table.
  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_valid[oct_pkg::NumCells-1] && !cell_data[oct_pkg::NumCells-1].zero)
      |-> cell_data[oct_pkg::NumCells-1].quo <= oct_pkg::MaxIdx)
    else $error("quotient beyond table range");

  // The origin always goes down the mirrored branch.
  a_origin_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    (fold_valid && fold_data.zero) |-> fold_data.mirror)
    else $error("origin not mirrored");

  // A delivered angle lies within a half turn either way.
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (angle >= -oct_pkg::HalfTurn) && (angle <= oct_pkg::HalfTurn))
    else $error("angle out of range");

endmodule

// ===== dv/testbench.sv =====
// testbench: self-checking bench for octant_lut_arctan2, a four-quadrant arctangent.
// Depends on rtl/oct_pkg.sv and rtl/octant_lut_arctan2.sv; predicts every angle on its own.
`timescale 1ns / 1ps
module testbench;

  localparam int RatioSteps   = 16;    // table resolution across one octant
  localparam int WatchdogMax  = 2000;  // cycles with no transaction before giving up
  localparam int DrainCycles  = 20;    // pipeline is 7 deep; leave some margin
  localparam int RandomPoints = 1430;
  localparam int ReportMax    = 10;

  // Arctangent over one octant, 0..45 degrees as 0..15, indexed by 16*small/large.
  int atan_step [17] = '{0, 1, 2, 3, 4, 5, 7, 8, 9, 10, 11, 12, 13, 13, 14, 15, 15};

  typedef struct {
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic signed [7:0]  angle;
  } point_angle_t;

  typedef struct {
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic               known;  // angle typed in below; otherwise predicted
    logic signed [7:0]  angle;
  } directed_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // [15:0] y_coord, [31:16] x_coord
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [7:0] angle

  point_angle_t  pending_angles[$];
  directed_row_t directed_rows[$];
  int            mismatches   = 0;
  int            idle_cycles  = 0;
  int            send_idle_pct = 32;
  int            recv_idle_pct = 64;

  octant_lut_arctan2 i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Angle in 1/128 turn: fold to the first quadrant by magnitude, look up the octant
  // angle, mirror about the diagonal when |y| >= |x|, then unfold by the signs.
  function automatic logic signed [7:0] arctan_angle(logic signed [15:0] y,
                                                     logic signed [15:0] x);
    int mag_y;
    int mag_x;
    int big;
    int little;
    int idx;
    int a;
    int r;
    logic mirror;
    mag_y  = (y < 0) ? -int'(y) : int'(y);  // -32768 becomes 32768, no wrap
    mag_x  = (x < 0) ? -int'(x) : int'(x);
    mirror = (mag_y >= mag_x);
    big    = mirror ? mag_y : mag_x;
    little = mirror ? mag_x : mag_y;
    if (big == 0) begin
      a = 0;  // origin: zero divisor, table value taken as zero
    end else begin
      idx = (RatioSteps * little) / big;
      if (idx > RatioSteps) idx = RatioSteps;
      a = atan_step[idx];
    end
    if (mirror) a = int'(oct_pkg::QuarterTurn) - a;
    case ({x[15], y[15]})
      2'b00:   r = a;
      2'b10:   r = int'(oct_pkg::HalfTurn) - a;
      2'b01:   r = -a;
      default: r = a - int'(oct_pkg::HalfTurn);
    endcase
    return 8'(r);
  endfunction

  task automatic add_row(int y, int x, logic known, int angle);
    directed_row_t row;
    row.y     = 16'(y);
    row.x     = 16'(x);
    row.known = known;
    row.angle = 8'(angle);
    directed_rows.push_back(row);
  endtask

  // Hold the point on the input until a transaction takes it, idling first at random.
  task automatic send_point(logic signed [15:0] y, logic signed [15:0] x,
                            logic signed [7:0] angle);
    point_angle_t item;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {x, y};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    item.y     = y;
    item.x     = x;
    item.angle = angle;
    pending_angles.push_back(item);
  endtask

  // Signed coordinate from a magnitude and a sign; 32768 only exists as a negative.
  function automatic logic signed [15:0] signed_coord(int mag, logic neg);
    if (mag >= 32768) return 16'sh8000;
    return neg ? 16'(-mag) : 16'(mag);
  endfunction

  task automatic random_point(output logic signed [15:0] y, output logic signed [15:0] x);
    int big;
    int little;
    int k;
    int pick [6] = '{-32768, -32767, -1, 0, 1, 32767};
    case ($urandom_range(9))
      4: begin
        // small magnitudes: dense coverage of the ratio grid near the origin
        y = 16'($signed($urandom_range(40)) - 20);
        x = 16'($signed($urandom_range(40)) - 20);
      end
      5, 6, 7: begin
        // ratios right at and beside a table index boundary
        big    = $urandom_range(32768, 1);
        k      = $urandom_range(RatioSteps);
        little = (big * k) / RatioSteps + $signed($urandom_range(2)) - 1;
        if (little < 0) little = 0;
        if (little > big) little = big;
        if ($urandom_range(1)) begin
          y = signed_coord(big, 1'($urandom_range(1)));
          x = signed_coord(little, 1'($urandom_range(1)));
        end else begin
          y = signed_coord(little, 1'($urandom_range(1)));
          x = signed_coord(big, 1'($urandom_range(1)));
        end
      end
      8: begin
        y = 16'(pick[$urandom_range(5)]);
        x = 16'(pick[$urandom_range(5)]);
      end
      9: begin
        // equal magnitudes in any quadrant
        big = $urandom_range(32768);
        y   = signed_coord(big, 1'($urandom_range(1)));
        x   = signed_coord(big, (big == 32768) ? 1'b1 : 1'(($urandom_range(1))));
      end
      default: begin
        y = 16'($urandom);
        x = 16'($urandom);
      end
    endcase
  endtask

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= ReportMax) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Receiver: check each result against the oldest pending angle, then pick the next ready.
  always @(posedge clk) begin
    point_angle_t item;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_angles.size() == 0) begin
        report_mismatch($sformatf("angle %0d with no point pending", $signed(out_tdata)));
      end else begin
        item = pending_angles.pop_front();
        if (out_tdata !== item.angle)
          report_mismatch($sformatf("y=%0d x=%0d: expected angle %0d, got %0d",
                                    item.y, item.x, item.angle, $signed(out_tdata)));
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: count cycles in which neither side moves a transaction.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogMax) begin
      $display("** octant_lut_arctan2: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic signed [15:0] y;
    logic signed [15:0] x;
    directed_row_t      row;

    // Directed points: origin, axes, diagonals, extremes, index boundaries.
    add_row(0, 0, 1, 32);             // origin
    add_row(0, 100, 1, 0);
    add_row(100, 0, 1, 32);
    add_row(0, -100, 1, 64);
    add_row(-100, 0, 1, -32);
    add_row(5, 5, 1, 17);             // equal magnitudes, each quadrant
    add_row(5, -5, 1, 47);
    add_row(-5, 5, 1, -17);
    add_row(-5, -5, 1, -47);
    add_row(-1, -1, 1, -47);
    add_row(32767, 32767, 1, 17);
    add_row(-32768, -32768, 1, -47);  // most negative on both axes
    add_row(-32768, 0, 1, -32);
    add_row(0, -32768, 1, 64);
    add_row(32767, -32768, 0, 0);
    add_row(-32768, 32767, 0, 0);
    add_row(-32768, 1, 0, 0);
    add_row(1, 32767, 0, 0);
    add_row(16, 32767, 0, 0);
    add_row(1, 16, 0, 0);
    add_row(15, 16, 0, 0);
    add_row(16, 15, 0, 0);
    add_row(16'sh5555, 16'shAAAA, 0, 0);
    add_row(16'shAAAA, 16'sh5555, 0, 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_point(row.y, row.x, row.known ? row.angle : arctan_angle(row.y, row.x));
    end

    // Random part in three idling phases: slow receiver, slow sender, full rate.
    for (int n = 0; n < RandomPoints; n++) begin
      if (n == RandomPoints / 3) begin
        send_idle_pct = 64;
        recv_idle_pct = 32;
      end else if (n == 2 * RandomPoints / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_point(y, x);
      send_point(y, x, arctan_angle(y, x));
    end
    in_tvalid <= 1'b0;

    while (pending_angles.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (pending_angles.size() != 0)
      report_mismatch($sformatf("%0d angles never arrived", pending_angles.size()));

    if (mismatches == 0) begin
      $display("** octant_lut_arctan2: PASSED **");
    end else begin
      $display("** octant_lut_arctan2: FAILED **");
    end
    $finish;
  end

endmodule
